FILE: sv/tvmt_pkg.sv
// tvmt_pkg: payload structs, register indexes, latency constants and width helpers
// for the two-view midpoint triangulation pipeline; no dependencies
`default_nettype none
package tvmt_pkg;

  typedef struct packed {
    logic signed [15:0] f1_x;
    logic signed [15:0] f1_y;
    logic signed [15:0] f1_z;
    logic signed [15:0] f2_x;
    logic signed [15:0] f2_y;
    logic signed [15:0] f2_z;
  } tvmt_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               singular;
    logic               overflow;
  } tvmt_out_t;

  typedef struct packed {
    logic [47:0]        rot_row_0;
    logic [47:0]        rot_row_1;
    logic [47:0]        rot_row_2;
    logic signed [23:0] trans_x;
    logic signed [23:0] trans_y;
    logic signed [23:0] trans_z;
  } tvmt_cfg_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ovf;
    logic               sing;
  } tvmt_coord_t;

  typedef enum logic [2:0] {
    REG_ROT_ROW_0 = 3'd0,
    REG_ROT_ROW_1 = 3'd1,
    REG_ROT_ROW_2 = 3'd2,
    REG_TRANS_X   = 3'd3,
    REG_TRANS_Y   = 3'd4,
    REG_TRANS_Z   = 3'd5
  } tvmt_reg_e;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 48;
  localparam int MulChunkW = 24;
  localparam int MulLat    = 4;
  localparam int QuotBits  = 33;
  localparam int OutShift  = 3;
  localparam int FrontLat  = 5;
  localparam int SolveLat  = 2 * MulLat + 2;
  localparam int DivLat    = QuotBits + 3;
  localparam int TotalLat  = FrontLat + SolveLat + DivLat;
  localparam logic [31:0] SatPos = 32'h7fff_ffff;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  function automatic int imax(int x, int y);
    return (x > y) ? x : y;
  endfunction

  function automatic int f2u_w(int frac);
    return 34 - frac;
  endfunction

  function automatic int dot_a_w(int frac);
    return 34 + 0 * frac;
  endfunction

  function automatic int dot_c_w(int frac);
    return 18 + f2u_w(frac);
  endfunction

  function automatic int dot_d_w(int frac);
    return 2 * f2u_w(frac) + 2;
  endfunction

  function automatic int dot_b0_w(int frac);
    return 42 + 0 * frac;
  endfunction

  function automatic int dot_b1_w(int frac);
    return 26 + f2u_w(frac);
  endfunction

  function automatic int big_w(int frac);
    int wdet;
    int wn0;
    int wn1;
    wdet = imax(2 * dot_c_w(frac), dot_a_w(frac) + dot_d_w(frac)) + 1;
    wn0  = imax(dot_c_w(frac) + dot_b1_w(frac), dot_d_w(frac) + dot_b0_w(frac)) + 1;
    wn1  = imax(dot_a_w(frac) + dot_b1_w(frac), dot_c_w(frac) + dot_b0_w(frac)) + 1;
    return imax(wdet, imax(wn0, wn1));
  endfunction

  function automatic int num_w(int frac);
    return big_w(frac) + 31;
  endfunction

  function automatic int rem_w(int frac);
    return big_w(frac) + 35;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tvmt_mul.sv
// tvmt_mul: four-stage signed multiplier built from 24x24 partial products
// depends on tvmt_pkg
`default_nettype none
module tvmt_mul import tvmt_pkg::*; #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  wire logic                 clk_i,
  input  wire logic signed [WA-1:0] a_i,
  input  wire logic signed [WB-1:0] b_i,
  output logic signed [WA+WB-1:0]   p_o
);
  localparam int NA  = (WA + MulChunkW - 1) / MulChunkW;
  localparam int NB  = (WB + MulChunkW - 1) / MulChunkW;
  localparam int PAW = NA * MulChunkW;
  localparam int PBW = NB * MulChunkW;
  localparam int PW  = PAW + PBW;

  logic [WA-1:0]  abs_a;
  logic [WB-1:0]  abs_b;
  logic [PAW-1:0] mag_a_q;
  logic [PBW-1:0] mag_b_q;
  logic           neg1_q, neg2_q, neg3_q;
  logic [2*MulChunkW-1:0] pp_q [NA][NB];
  logic [PW-1:0]  sum_d, sum_q, sgn;
  logic signed [WA+WB-1:0] p_q;

  assign abs_a = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
  assign abs_b = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);

  always_ff @(posedge clk_i) begin
    mag_a_q <= PAW'(abs_a);
    mag_b_q <= PBW'(abs_b);
    neg1_q  <= a_i[WA-1] ^ b_i[WB-1];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= mag_a_q[i*MulChunkW +: MulChunkW] * mag_b_q[j*MulChunkW +: MulChunkW];
      end
    end
    neg2_q <= neg1_q;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i][j]) << ((i + j) * MulChunkW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    neg3_q <= neg2_q;
  end

  assign sgn = neg3_q ? (~sum_q + PW'(1)) : sum_q;

  always_ff @(posedge clk_i) begin
    p_q <= sgn[WA+WB-1:0];
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: sv/tvmt_front.sv
// tvmt_front: rotation of the second bearing, rounding, and the five dot products
// depends on tvmt_pkg
`default_nettype none
module tvmt_front import tvmt_pkg::*; #(
  parameter int FRAC = 14
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire tvmt_in_t  item_i,
  input  wire tvmt_cfg_t cfg_i,
  output logic           valid_o,
  output logic signed [15:0]                 f1_o  [3],
  output logic signed [f2u_w(FRAC)-1:0]      f2u_o [3],
  output logic signed [dot_a_w(FRAC)-1:0]    a_o,
  output logic signed [dot_c_w(FRAC)-1:0]    c_o,
  output logic signed [dot_d_w(FRAC)-1:0]    d_o,
  output logic signed [dot_b0_w(FRAC)-1:0]   b0_o,
  output logic signed [dot_b1_w(FRAC)-1:0]   b1_o
);
  localparam int FW  = f2u_w(FRAC);
  localparam int AW  = dot_a_w(FRAC);
  localparam int CW  = dot_c_w(FRAC);
  localparam int DW  = dot_d_w(FRAC);
  localparam int B0W = dot_b0_w(FRAC);
  localparam int B1W = dot_b1_w(FRAC);

  logic [FrontLat-1:0] vld_q;
  logic [47:0]        rows [3];
  logic signed [15:0] f1_in [3];
  logic signed [15:0] f2_in [3];
  logic signed [23:0] tv [3];
  logic signed [15:0] f1_dl [FrontLat][3];
  logic signed [31:0] prod_q [3][3];
  logic signed [33:0] acc_q [3];
  logic signed [FW-1:0] f2u_d [3];
  logic signed [FW-1:0] f2u_q [3];
  logic signed [FW-1:0] f2u_dl [3];
  logic signed [31:0]       pa_q  [3];
  logic signed [16+FW-1:0]  pc_q  [3];
  logic signed [2*FW-1:0]   pd_q  [3];
  logic signed [39:0]       pb0_q [3];
  logic signed [24+FW-1:0]  pb1_q [3];
  logic signed [AW-1:0]  a_q;
  logic signed [CW-1:0]  c_q;
  logic signed [DW-1:0]  d_q;
  logic signed [B0W-1:0] b0_q;
  logic signed [B1W-1:0] b1_q;

  assign rows[0] = cfg_i.rot_row_0;
  assign rows[1] = cfg_i.rot_row_1;
  assign rows[2] = cfg_i.rot_row_2;
  assign f1_in[0] = item_i.f1_x;
  assign f1_in[1] = item_i.f1_y;
  assign f1_in[2] = item_i.f1_z;
  assign f2_in[0] = item_i.f2_x;
  assign f2_in[1] = item_i.f2_y;
  assign f2_in[2] = item_i.f2_z;
  assign tv[0] = cfg_i.trans_x;
  assign tv[1] = cfg_i.trans_y;
  assign tv[2] = cfg_i.trans_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    f1_dl[0] <= f1_in;
    for (int s = 1; s < FrontLat; s++) begin
      f1_dl[s] <= f1_dl[s-1];
    end
  end

  // rotate f2 into the first frame
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= $signed(rows[i][16*j +: 16]) * f2_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      acc_q[i] <= 34'(prod_q[i][0]) + 34'(prod_q[i][1]) + 34'(prod_q[i][2]);
    end
  end

  // round to nearest, ties away from zero
  always_comb begin
    logic [33:0] m;
    logic [34:0] rnd;
    logic [FW-1:0] rm;
    for (int i = 0; i < 3; i++) begin
      m   = acc_q[i][33] ? 34'(-acc_q[i]) : 34'(acc_q[i]);
      rnd = (35'(m) + (35'(1) << (FRAC - 1))) >> FRAC;
      rm  = rnd[FW-1:0];
      f2u_d[i] = acc_q[i][33] ? -$signed(rm) : $signed(rm);
    end
  end

  always_ff @(posedge clk_i) begin
    f2u_q <= f2u_d;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pa_q[i]  <= f1_dl[2][i] * f1_dl[2][i];
      pc_q[i]  <= f1_dl[2][i] * f2u_q[i];
      pd_q[i]  <= f2u_q[i] * f2u_q[i];
      pb0_q[i] <= tv[i] * f1_dl[2][i];
      pb1_q[i] <= tv[i] * f2u_q[i];
    end
    f2u_dl <= f2u_q;
  end

  always_ff @(posedge clk_i) begin
    a_q  <= AW'(pa_q[0]) + AW'(pa_q[1]) + AW'(pa_q[2]);
    c_q  <= CW'(pc_q[0]) + CW'(pc_q[1]) + CW'(pc_q[2]);
    d_q  <= DW'(pd_q[0]) + DW'(pd_q[1]) + DW'(pd_q[2]);
    b0_q <= B0W'(pb0_q[0]) + B0W'(pb0_q[1]) + B0W'(pb0_q[2]);
    b1_q <= B1W'(pb1_q[0]) + B1W'(pb1_q[1]) + B1W'(pb1_q[2]);
    f2u_o <= f2u_dl;
  end

  assign valid_o = vld_q[FrontLat-1];
  assign f1_o    = f1_dl[FrontLat-1];
  assign a_o     = a_q;
  assign c_o     = c_q;
  assign d_o     = d_q;
  assign b0_o    = b0_q;
  assign b1_o    = b1_q;

endmodule
`default_nettype wire

FILE: sv/tvmt_solve.sv
// tvmt_solve: determinant, adjugate numerators and the per-axis numerators
// depends on tvmt_pkg and tvmt_mul
`default_nettype none
module tvmt_solve import tvmt_pkg::*; #(
  parameter int FRAC = 14
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire tvmt_cfg_t cfg_i,
  input  wire logic signed [15:0]               f1_i  [3],
  input  wire logic signed [f2u_w(FRAC)-1:0]    f2u_i [3],
  input  wire logic signed [dot_a_w(FRAC)-1:0]  a_i,
  input  wire logic signed [dot_c_w(FRAC)-1:0]  c_i,
  input  wire logic signed [dot_d_w(FRAC)-1:0]  d_i,
  input  wire logic signed [dot_b0_w(FRAC)-1:0] b0_i,
  input  wire logic signed [dot_b1_w(FRAC)-1:0] b1_i,
  output logic                                  valid_o,
  output logic signed [num_w(FRAC)-1:0]         num_o [3],
  output logic signed [big_w(FRAC)-1:0]         det_o,
  output logic                                  sing_o
);
  localparam int FW  = f2u_w(FRAC);
  localparam int AW  = dot_a_w(FRAC);
  localparam int CW  = dot_c_w(FRAC);
  localparam int DW  = dot_d_w(FRAC);
  localparam int B0W = dot_b0_w(FRAC);
  localparam int B1W = dot_b1_w(FRAC);
  localparam int BW  = big_w(FRAC);
  localparam int NW  = num_w(FRAC);
  localparam int DL  = MulLat + 1;

  logic [SolveLat-1:0] vld_q;
  logic signed [2*CW-1:0]    m_cc;
  logic signed [AW+DW-1:0]   m_ad;
  logic signed [CW+B1W-1:0]  m_cb1;
  logic signed [DW+B0W-1:0]  m_db0;
  logic signed [AW+B1W-1:0]  m_ab1;
  logic signed [CW+B0W-1:0]  m_cb0;
  logic signed [15:0]    f1_dl  [DL][3];
  logic signed [FW-1:0]  f2u_dl [DL][3];
  logic signed [BW-1:0]  det_q, n0_q, n1_q;
  logic signed [BW-1:0]  det_dl [DL];
  logic signed [23:0]    tv [3];
  logic signed [BW+15:0]   m_n0 [3];
  logic signed [BW+FW-1:0] m_n1 [3];
  logic signed [BW+23:0]   m_dt [3];
  logic signed [NW-1:0]    num_d [3];
  logic signed [NW-1:0]    num_q [3];
  logic                    sing_q;

  assign tv[0] = cfg_i.trans_x;
  assign tv[1] = cfg_i.trans_y;
  assign tv[2] = cfg_i.trans_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SolveLat-2:0], valid_i};
    end
  end

  tvmt_mul #(.WA(CW), .WB(CW))   u_mul_cc  (.clk_i, .a_i(c_i), .b_i(c_i),  .p_o(m_cc));
  tvmt_mul #(.WA(AW), .WB(DW))   u_mul_ad  (.clk_i, .a_i(a_i), .b_i(d_i),  .p_o(m_ad));
  tvmt_mul #(.WA(CW), .WB(B1W))  u_mul_cb1 (.clk_i, .a_i(c_i), .b_i(b1_i), .p_o(m_cb1));
  tvmt_mul #(.WA(DW), .WB(B0W))  u_mul_db0 (.clk_i, .a_i(d_i), .b_i(b0_i), .p_o(m_db0));
  tvmt_mul #(.WA(AW), .WB(B1W))  u_mul_ab1 (.clk_i, .a_i(a_i), .b_i(b1_i), .p_o(m_ab1));
  tvmt_mul #(.WA(CW), .WB(B0W))  u_mul_cb0 (.clk_i, .a_i(c_i), .b_i(b0_i), .p_o(m_cb0));

  always_ff @(posedge clk_i) begin
    f1_dl[0]  <= f1_i;
    f2u_dl[0] <= f2u_i;
    for (int s = 1; s < DL; s++) begin
      f1_dl[s]  <= f1_dl[s-1];
      f2u_dl[s] <= f2u_dl[s-1];
    end
  end

  // normal system by adjugate
  always_ff @(posedge clk_i) begin
    det_q <= BW'(m_cc) - BW'(m_ad);
    n0_q  <= BW'(m_cb1) - BW'(m_db0);
    n1_q  <= BW'(m_ab1) - BW'(m_cb0);
  end

  always_ff @(posedge clk_i) begin
    det_dl[0] <= det_q;
    for (int s = 1; s < DL; s++) begin
      det_dl[s] <= det_dl[s-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    tvmt_mul #(.WA(BW), .WB(16)) u_mul_n0 (
      .clk_i, .a_i(n0_q), .b_i(f1_dl[DL-1][i]), .p_o(m_n0[i])
    );
    tvmt_mul #(.WA(BW), .WB(FW)) u_mul_n1 (
      .clk_i, .a_i(n1_q), .b_i(f2u_dl[DL-1][i]), .p_o(m_n1[i])
    );
    tvmt_mul #(.WA(BW), .WB(24)) u_mul_dt (
      .clk_i, .a_i(det_q), .b_i(tv[i]), .p_o(m_dt[i])
    );
  end

  always_comb begin
    logic signed [NW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      s = NW'(m_n0[i]) + NW'(m_n1[i]) + NW'(m_dt[i]);
      num_d[i] = s <<< OutShift;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    det_o  <= det_dl[DL-2];
    sing_q <= (det_dl[DL-2] == '0);
  end

  assign valid_o = vld_q[SolveLat-1];
  assign num_o   = num_q;
  assign sing_o  = sing_q;

endmodule
`default_nettype wire

FILE: sv/tvmt_div.sv
// tvmt_div: pipelined restoring divider, one quotient bit per stage, with
// round-half-away and saturation to signed Q16.16; depends on tvmt_pkg
`default_nettype none
module tvmt_div import tvmt_pkg::*; #(
  parameter int NW = 64,
  parameter int BW = 32,
  parameter int WR = 67
) (
  input  wire logic                 clk_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic signed [BW-1:0] det_i,
  input  wire logic                 sing_i,
  output tvmt_coord_t               coord_o
);
  logic [NW-1:0] nm_q;
  logic [BW-1:0] dma_q;
  logic          nega_q, sga_q;
  logic [WR-1:0]       r_q   [QuotBits+1];
  logic [QuotBits-1:0] q_q   [QuotBits+1];
  logic [BW-1:0]       dm_q  [QuotBits+1];
  logic                neg_q [QuotBits+1];
  logic                pov_q [QuotBits+1];
  logic                sg_q  [QuotBits+1];
  logic                rnd_up, ovf;
  logic [QuotBits:0]   q1, lim;
  tvmt_coord_t         coord_d, coord_q;

  always_ff @(posedge clk_i) begin
    nm_q   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    dma_q  <= det_i[BW-1] ? BW'(-det_i) : BW'(det_i);
    nega_q <= num_i[NW-1] ^ det_i[BW-1];
    sga_q  <= sing_i;
  end

  // quotients of 2^33 and above always saturate
  always_ff @(posedge clk_i) begin
    r_q[0]   <= WR'(nm_q);
    q_q[0]   <= '0;
    dm_q[0]  <= dma_q;
    neg_q[0] <= nega_q;
    pov_q[0] <= WR'(nm_q) >= (WR'(dma_q) << QuotBits);
    sg_q[0]  <= sga_q;
  end

  for (genvar s = 0; s < QuotBits; s++) begin : g_bit
    localparam int Bit = QuotBits - 1 - s;
    logic [WR-1:0] sh;
    logic          ge;
    assign sh = WR'(dm_q[s]) << Bit;
    assign ge = (r_q[s] >= sh);
    always_ff @(posedge clk_i) begin
      r_q[s+1]   <= ge ? (r_q[s] - sh) : r_q[s];
      q_q[s+1]   <= q_q[s] | (ge ? (QuotBits'(1) << Bit) : '0);
      dm_q[s+1]  <= dm_q[s];
      neg_q[s+1] <= neg_q[s];
      pov_q[s+1] <= pov_q[s];
      sg_q[s+1]  <= sg_q[s];
    end
  end

  assign rnd_up = ((BW+1)'(r_q[QuotBits][BW-1:0]) << 1) >= (BW+1)'(dm_q[QuotBits]);
  assign q1  = {1'b0, q_q[QuotBits]} + (QuotBits+1)'(rnd_up);
  assign lim = neg_q[QuotBits] ? (QuotBits+1)'(SatNeg) : (QuotBits+1)'(SatPos);
  assign ovf = pov_q[QuotBits] || (q1 > lim);

  always_comb begin
    coord_d.sing = sg_q[QuotBits];
    if (sg_q[QuotBits]) begin
      coord_d.value = '0;
      coord_d.ovf   = 1'b0;
    end else if (ovf) begin
      coord_d.value = neg_q[QuotBits] ? SatNeg : SatPos;
      coord_d.ovf   = 1'b1;
    end else begin
      coord_d.value = neg_q[QuotBits] ? -q1[31:0] : q1[31:0];
      coord_d.ovf   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
  end

  assign coord_o = coord_q;

endmodule
`default_nettype wire

FILE: sv/two_view_midpoint_triangulation.sv
// Two-view midpoint triangulation. One bearing pair is taken in every clock cycle (busy_o
// stays low); its point appears on res_o with done_o high once the start transfer has
// passed the pipeline: rotation and dot products (tvmt_front), determinant and numerator
// products on 24-bit partial multipliers (tvmt_solve), and division, one quotient bit per
// stage (tvmt_div). Each result is shown for one cycle only and is lost if not captured.
// Configuration writes must only be made while the pipeline is empty.
// Depends on tvmt_pkg, tvmt_front, tvmt_solve, tvmt_div.
`default_nettype none
module two_view_midpoint_triangulation import tvmt_pkg::*; #(
  parameter int BEARING_FRAC_BITS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire tvmt_in_t            item_i,
  output logic                     busy_o,
  output logic                     done_o,
  output tvmt_out_t                res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  localparam int FW  = f2u_w(BEARING_FRAC_BITS);
  localparam int AW  = dot_a_w(BEARING_FRAC_BITS);
  localparam int CW  = dot_c_w(BEARING_FRAC_BITS);
  localparam int DW  = dot_d_w(BEARING_FRAC_BITS);
  localparam int B0W = dot_b0_w(BEARING_FRAC_BITS);
  localparam int B1W = dot_b1_w(BEARING_FRAC_BITS);
  localparam int BW  = big_w(BEARING_FRAC_BITS);
  localparam int NW  = num_w(BEARING_FRAC_BITS);
  localparam int WR  = rem_w(BEARING_FRAC_BITS);

  tvmt_cfg_t cfg_q;
  logic      fr_valid, sv_valid;
  logic signed [15:0]    f1   [3];
  logic signed [FW-1:0]  f2u  [3];
  logic signed [AW-1:0]  a;
  logic signed [CW-1:0]  c;
  logic signed [DW-1:0]  d;
  logic signed [B0W-1:0] b0;
  logic signed [B1W-1:0] b1;
  logic signed [NW-1:0]  num [3];
  logic signed [BW-1:0]  det;
  logic                  sing;
  tvmt_coord_t           coord [3];
  logic [DivLat-1:0]     vld_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROT_ROW_0: cfg_q.rot_row_0 <= cfg_data_i;
        REG_ROT_ROW_1: cfg_q.rot_row_1 <= cfg_data_i;
        REG_ROT_ROW_2: cfg_q.rot_row_2 <= cfg_data_i;
        REG_TRANS_X:   cfg_q.trans_x   <= cfg_data_i[23:0];
        REG_TRANS_Y:   cfg_q.trans_y   <= cfg_data_i[23:0];
        REG_TRANS_Z:   cfg_q.trans_z   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  tvmt_front #(.FRAC(BEARING_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i (start_i & ~busy_o),
    .item_i,
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .f1_o    (f1),
    .f2u_o   (f2u),
    .a_o     (a),
    .c_o     (c),
    .d_o     (d),
    .b0_o    (b0),
    .b1_o    (b1)
  );

  tvmt_solve #(.FRAC(BEARING_FRAC_BITS)) u_solve (
    .clk_i, .rst_ni,
    .valid_i (fr_valid),
    .cfg_i   (cfg_q),
    .f1_i    (f1),
    .f2u_i   (f2u),
    .a_i     (a),
    .c_i     (c),
    .d_i     (d),
    .b0_i    (b0),
    .b1_i    (b1),
    .valid_o (sv_valid),
    .num_o   (num),
    .det_o   (det),
    .sing_o  (sing)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    tvmt_div #(.NW(NW), .BW(BW), .WR(WR)) u_div (
      .clk_i,
      .num_i   (num[i]),
      .det_i   (det),
      .sing_i  (sing),
      .coord_o (coord[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivLat-2:0], sv_valid};
    end
  end

  assign done_o         = vld_q[DivLat-1];
  assign res_o.point_x  = coord[0].value;
  assign res_o.point_y  = coord[1].value;
  assign res_o.point_z  = coord[2].value;
  assign res_o.singular = coord[0].sing;
  assign res_o.overflow = coord[0].ovf | coord[1].ovf | coord[2].ovf;

endmodule
`default_nettype wire

FILE: sv/tvmt_chk.sv
// tvmt_chk: port-level checks on the triangulation block, bound to its top level
// depends on tvmt_pkg
`default_nettype none
module tvmt_chk import tvmt_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire tvmt_in_t            item_i,
  input wire logic                busy_o,
  input wire logic                done_o,
  input wire tvmt_out_t           res_o,
  input wire logic                cfg_we_i,
  input wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [CfgDataW-1:0] cfg_data_i
);

  // every start transfer yields its result after the fixed latency
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##TotalLat done_o)
    else $error("result missing after start transfer");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, TotalLat))
    else $error("result without a start transfer");

  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.singular) |->
      (res_o.point_x == 0 && res_o.point_y == 0 && res_o.point_z == 0 && !res_o.overflow))
    else $error("singular result not zeroed");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflow) |->
      (res_o.point_x == SatPos || res_o.point_x == SatNeg ||
       res_o.point_y == SatPos || res_o.point_y == SatNeg ||
       res_o.point_z == SatPos || res_o.point_z == SatNeg))
    else $error("overflow flagged without a saturated coordinate");

endmodule

bind two_view_midpoint_triangulation tvmt_chk u_chk (.*);
`default_nettype wire
